FILE: hw/rtl/calendar_time_of_day_counter_core_assert.svh
// ----------------------------------------------------------------------------
// Calendar clock counter assertion macros
// Shared property wrappers for the calendar clock counter checkers.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_TIME_OF_DAY_COUNTER_CORE_ASSERT_SVH
`define CALENDAR_TIME_OF_DAY_COUNTER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define CTOD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CTOD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ctod_pkg.sv
// ----------------------------------------------------------------------------
// Calendar clock counter package
// Widths, limits, reset month words, codes and field helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctod_pkg;

    localparam int HOURS_IN_DAY   = 24;
    localparam int MONTHS_IN_YEAR = 4;
    localparam int DAYS_IN_WEEK   = 3;

    localparam int HOUR_W    = 5;
    localparam int WDAY_W    = 2;
    localparam int MDAY_W    = 6;
    localparam int MONTH_W   = 2;
    localparam int YEAR_W    = 16;
    localparam int PHASE_W   = 2;
    localparam int C12_W     = 4;
    localparam int NUM_PHASE = 4;
    localparam int WORD_W    = 26;
    localparam int START_W   = 5;
    localparam int NUM_MONTH = 2 ** MONTH_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [HOUR_W-1:0] HALF_DAY = HOUR_W'(HOURS_IN_DAY / 2);
    localparam logic [YEAR_W-1:0] YEAR_MAX = '1;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_LOAD = 1'b1
    } t_kind;

    typedef enum logic [PHASE_W-1:0] {
        PH_MORNING   = 2'd0,
        PH_AFTERNOON = 2'd1,
        PH_EVENING   = 2'd2,
        PH_NIGHT     = 2'd3
    } t_phase;

    typedef logic [WORD_W-1:0] t_month_word;

    typedef struct packed {
        logic [HOUR_W-1:0]  hour;
        logic [WDAY_W-1:0]  wday;
        logic [MDAY_W-1:0]  mday;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_time;

    localparam t_month_word WORD_RESET [NUM_MONTH] = '{
        26'd47341982,
        26'd49500446,
        26'd45179294,
        26'd43018590
    };

    function automatic logic [MDAY_W-1:0] word_days(input t_month_word w);
        return w[MDAY_W-1:0];
    endfunction

    function automatic logic [START_W-1:0] word_start(input t_month_word w,
                                                     input int which);
        return w[MDAY_W + START_W * which +: START_W];
    endfunction

endpackage

FILE: hw/rtl/calendar_time_of_day_counter_core.sv
// ----------------------------------------------------------------------------
// Calendar clock counter core
// Hour, weekday, day of month, month and year counter with per-month phases.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the result side is not stalled and returns
// one result per request: an input register, then one pass of rollover and phase
// compare logic into the result register. The carry chain from hour to year and
// the lookup of the new month's word set the path between the two. While a result
// waits, requests stall once the input register is full. Month words must be
// written over the config port only while no request is in flight; the core does
// not enforce this. A write to the current month takes effect at once.
`timescale 1ns / 1ps

module calendar_time_of_day_counter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ctod_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ctod_pkg::WORD_W-1:0]      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [ctod_pkg::HOUR_W-1:0]      i_load_hour,
    input  logic [ctod_pkg::WDAY_W-1:0]      i_load_weekday,
    input  logic [ctod_pkg::MDAY_W-1:0]      i_load_monthday,
    input  logic [ctod_pkg::MONTH_W-1:0]     i_load_month,
    input  logic [ctod_pkg::YEAR_W-1:0]      i_load_year,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ctod_pkg::HOUR_W-1:0]      o_hour_now,
    output logic [ctod_pkg::WDAY_W-1:0]      o_weekday_now,
    output logic [ctod_pkg::MDAY_W-1:0]      o_monthday_now,
    output logic [ctod_pkg::MONTH_W-1:0]     o_month_now,
    output logic [ctod_pkg::YEAR_W-1:0]      o_year_now,
    output logic [ctod_pkg::PHASE_W-1:0]     o_phase,
    output logic                             o_is_pm,
    output logic [ctod_pkg::C12_W-1:0]       o_clock12,
    output logic [ctod_pkg::NUM_PHASE-1:0]   o_phase_starts
);

    import ctod_pkg::*;

    logic                  r_in_valid;
    t_kind                 r_in_kind;
    t_time                 r_in_load;
    t_time                 r_time;
    t_time                 n_time;
    t_month_word           r_month_word [NUM_MONTH];
    t_month_word           r_cur_word;
    t_month_word           n_word;
    logic                  r_out_valid;
    t_time                 r_out_time;
    t_phase                r_out_phase;
    t_phase                n_phase;
    logic                  r_out_pm;
    logic                  n_pm;
    logic [C12_W-1:0]      r_out_c12;
    logic [C12_W-1:0]      n_c12;
    logic [NUM_PHASE-1:0]  r_out_starts;
    logic [NUM_PHASE-1:0]  n_starts;

    logic                  out_adv;
    logic                  in_acc;
    logic                  fire;
    logic [HOUR_W:0]       hour_inc;
    logic                  day_roll;
    logic [WDAY_W:0]       wday_inc;
    logic [MDAY_W:0]       mday_inc;
    logic                  mon_wrap;
    logic [MONTH_W:0]      month_inc;
    logic                  year_wrap;
    t_time                 tick_time;
    logic [HOUR_W-1:0]     c12_full;

    assign out_adv    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign fire       = r_in_valid && out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_kind       <= t_kind'(i_kind);
            r_in_load.hour  <= i_load_hour;
            r_in_load.wday  <= i_load_weekday;
            r_in_load.mday  <= i_load_monthday;
            r_in_load.month <= i_load_month;
            r_in_load.year  <= i_load_year;
        end
    end

    // tick: cascaded rollover
    always_comb begin
        hour_inc  = {1'b0, r_time.hour} + 1'b1;
        day_roll  = hour_inc >= (HOUR_W + 1)'(HOURS_IN_DAY);
        wday_inc  = {1'b0, r_time.wday} + (WDAY_W + 1)'(day_roll);
        mday_inc  = {1'b0, r_time.mday} + (MDAY_W + 1)'(day_roll);
        mon_wrap  = mday_inc >= {1'b0, word_days(r_cur_word)};
        month_inc = {1'b0, r_time.month} + (MONTH_W + 1)'(mon_wrap);
        year_wrap = month_inc >= (MONTH_W + 1)'(MONTHS_IN_YEAR);

        tick_time.hour  = day_roll ? '0 : hour_inc[HOUR_W-1:0];
        tick_time.wday  = (wday_inc >= (WDAY_W + 1)'(DAYS_IN_WEEK)) ? '0
                                                                    : wday_inc[WDAY_W-1:0];
        tick_time.mday  = mon_wrap ? '0 : mday_inc[MDAY_W-1:0];
        tick_time.month = year_wrap ? '0 : month_inc[MONTH_W-1:0];
        tick_time.year  = (year_wrap && (r_time.year != YEAR_MAX)) ? r_time.year + 1'b1
                                                                  : r_time.year;

        n_time = (r_in_kind == KIND_LOAD) ? r_in_load : tick_time;
        n_word = r_month_word[n_time.month];
    end

    always_comb begin
        for (int i = 0; i < NUM_PHASE; i++) begin
            n_starts[i] = (r_in_kind == KIND_TICK) && (n_time.hour == word_start(n_word, i));
        end

        if (n_time.hour >= word_start(n_word, 0) && n_time.hour < word_start(n_word, 1)) begin
            n_phase = PH_MORNING;
        end else if (n_time.hour >= word_start(n_word, 1)
                     && n_time.hour < word_start(n_word, 2)) begin
            n_phase = PH_AFTERNOON;
        end else if (n_time.hour >= word_start(n_word, 2)
                     && n_time.hour < word_start(n_word, 3)) begin
            n_phase = PH_EVENING;
        end else begin
            n_phase = PH_NIGHT;
        end

        n_pm     = n_time.hour >= HALF_DAY;
        c12_full = n_pm ? n_time.hour - HALF_DAY : n_time.hour;
        if (c12_full == '0) begin
            c12_full = HALF_DAY;
        end
        n_c12 = c12_full[C12_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (fire) begin
            r_time <= n_time;
        end
    end

    // month word table; the current month's word is kept alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_MONTH; m++) begin
                r_month_word[m] <= WORD_RESET[m];
            end
            r_cur_word <= WORD_RESET[0];
        end else if (i_cfg_we) begin
            r_month_word[i_cfg_idx] <= i_cfg_data;
            if (i_cfg_idx == r_time.month) begin
                r_cur_word <= i_cfg_data;
            end
        end else if (fire) begin
            r_cur_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_time   <= n_time;
            r_out_phase  <= n_phase;
            r_out_pm     <= n_pm;
            r_out_c12    <= n_c12;
            r_out_starts <= n_starts;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hour_now     = r_out_time.hour;
    assign o_weekday_now  = r_out_time.wday;
    assign o_monthday_now = r_out_time.mday;
    assign o_month_now    = r_out_time.month;
    assign o_year_now     = r_out_time.year;
    assign o_phase        = r_out_phase;
    assign o_is_pm        = r_out_pm;
    assign o_clock12      = r_out_c12;
    assign o_phase_starts = r_out_starts;

endmodule

FILE: hw/rtl/ctod_checker.sv
// ----------------------------------------------------------------------------
// Calendar clock counter checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "calendar_time_of_day_counter_core_assert.svh"

module ctod_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [ctod_pkg::HOUR_W-1:0]      o_hour_now,
    input logic [ctod_pkg::YEAR_W-1:0]      o_year_now,
    input logic                             o_is_pm,
    input logic [ctod_pkg::C12_W-1:0]       o_clock12
);

    import ctod_pkg::*;

    `CTOD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_hour_now) && $stable(o_year_now), "stalled result changed")

    `CTOD_ASSERT_NOW(a_pm_match, i_clk, i_rst_n, o_out_valid, o_is_pm == (o_hour_now >= HALF_DAY), "pm flag disagrees with hour")

    `CTOD_ASSERT_NOW(a_c12_range, i_clk, i_rst_n, o_out_valid && (o_hour_now < HOUR_W'(HOURS_IN_DAY)), (o_clock12 != '0) && (o_clock12 <= C12_W'(HALF_DAY)), "twelve-hour value out of range")

endmodule

bind calendar_time_of_day_counter_core ctod_checker u_ctod_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_hour_now  (o_hour_now),
    .o_year_now  (o_year_now),
    .o_is_pm     (o_is_pm),
    .o_clock12   (o_clock12)
);

FILE: tb/sv/tb_calendar_time_of_day_counter_core.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Calendar clock counter testbench
// Sends tick and load requests with random gaps on both handshakes. Each
// accepted request is run through a local copy of the counters and month
// words, and every readout is compared field by field in order. Month words
// are rewritten between phases, including all-zero and all-one words.
// ----------------------------------------------------------------------------

module tb_calendar_time_of_day_counter_core;
    import ctod_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 300;

    typedef struct packed {
        t_kind              kind;
        logic [HOUR_W-1:0]  hour;
        logic [WDAY_W-1:0]  wday;
        logic [MDAY_W-1:0]  mday;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_cal_request;

    typedef struct packed {
        logic [HOUR_W-1:0]    hour;
        logic [WDAY_W-1:0]    wday;
        logic [MDAY_W-1:0]    mday;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
        t_phase               phase;
        logic                 is_pm;
        logic [C12_W-1:0]     clock12;
        logic [NUM_PHASE-1:0] starts;
    } t_readout;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WORD_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_kind;
    logic [HOUR_W-1:0]    i_load_hour;
    logic [WDAY_W-1:0]    i_load_weekday;
    logic [MDAY_W-1:0]    i_load_monthday;
    logic [MONTH_W-1:0]   i_load_month;
    logic [YEAR_W-1:0]    i_load_year;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [HOUR_W-1:0]    o_hour_now;
    logic [WDAY_W-1:0]    o_weekday_now;
    logic [MDAY_W-1:0]    o_monthday_now;
    logic [MONTH_W-1:0]   o_month_now;
    logic [YEAR_W-1:0]    o_year_now;
    logic [PHASE_W-1:0]   o_phase;
    logic                 o_is_pm;
    logic [C12_W-1:0]     o_clock12;
    logic [NUM_PHASE-1:0] o_phase_starts;

    t_month_word        cal_words [NUM_MONTH];
    logic [HOUR_W-1:0]  cal_hour;
    logic [WDAY_W-1:0]  cal_wday;
    logic [MDAY_W-1:0]  cal_mday;
    logic [MONTH_W-1:0] cal_month;
    logic [YEAR_W-1:0]  cal_year;

    t_readout pending_readouts [$];
    int       mismatch_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       holdoff_left;
    int       quiet_cycles;

    calendar_time_of_day_counter_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_load_hour     (i_load_hour),
        .i_load_weekday  (i_load_weekday),
        .i_load_monthday (i_load_monthday),
        .i_load_month    (i_load_month),
        .i_load_year     (i_load_year),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hour_now      (o_hour_now),
        .o_weekday_now   (o_weekday_now),
        .o_monthday_now  (o_monthday_now),
        .o_month_now     (o_month_now),
        .o_year_now      (o_year_now),
        .o_phase         (o_phase),
        .o_is_pm         (o_is_pm),
        .o_clock12       (o_clock12),
        .o_phase_starts  (o_phase_starts)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_readout advance_calendar(t_cal_request rq);
        logic [HOUR_W:0]    nxt_hour;
        logic [WDAY_W:0]    nxt_wday;
        logic [MDAY_W:0]    nxt_mday;
        logic [MONTH_W:0]   nxt_month;
        t_month_word        w;
        logic [START_W-1:0] st [NUM_PHASE];
        logic [HOUR_W-1:0]  c12;
        t_readout           r;
        r = '0;
        if (rq.kind == KIND_LOAD) begin
            cal_hour  = rq.hour;
            cal_wday  = rq.wday;
            cal_mday  = rq.mday;
            cal_month = rq.month;
            cal_year  = rq.year;
        end else begin
            nxt_hour  = cal_hour + 1'b1;
            nxt_wday  = cal_wday;
            nxt_mday  = cal_mday;
            nxt_month = cal_month;
            if (nxt_hour >= HOURS_IN_DAY) begin
                nxt_hour = '0;
                nxt_wday = nxt_wday + 1'b1;
                nxt_mday = nxt_mday + 1'b1;
            end
            if (nxt_wday >= DAYS_IN_WEEK)
                nxt_wday = '0;
            if (nxt_mday >= cal_words[cal_month][MDAY_W-1:0]) begin
                nxt_mday  = '0;
                nxt_month = nxt_month + 1'b1;
            end
            if (nxt_month >= MONTHS_IN_YEAR) begin
                nxt_month = '0;
                if (cal_year != YEAR_MAX)
                    cal_year = cal_year + 1'b1;
            end
            cal_hour  = nxt_hour[HOUR_W-1:0];
            cal_wday  = nxt_wday[WDAY_W-1:0];
            cal_mday  = nxt_mday[MDAY_W-1:0];
            cal_month = nxt_month[MONTH_W-1:0];
        end

        w = cal_words[cal_month];
        for (int i = 0; i < NUM_PHASE; i++)
            st[i] = w[MDAY_W + START_W * i +: START_W];
        if (rq.kind == KIND_TICK)
            for (int i = 0; i < NUM_PHASE; i++)
                r.starts[i] = (cal_hour == st[i]);

        if (cal_hour >= st[0] && cal_hour < st[1])
            r.phase = PH_MORNING;
        else if (cal_hour >= st[1] && cal_hour < st[2])
            r.phase = PH_AFTERNOON;
        else if (cal_hour >= st[2] && cal_hour < st[3])
            r.phase = PH_EVENING;
        else
            r.phase = PH_NIGHT;

        r.is_pm = (cal_hour >= HALF_DAY);
        c12 = r.is_pm ? cal_hour - HALF_DAY : cal_hour;
        if (c12 == '0)
            c12 = HALF_DAY;
        r.clock12 = c12[C12_W-1:0];
        r.hour    = cal_hour;
        r.wday    = cal_wday;
        r.mday    = cal_mday;
        r.month   = cal_month;
        r.year    = cal_year;
        return r;
    endfunction

    task automatic report_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cal_request rq;
        t_readout     exp_r;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                rq.kind  = t_kind'(i_kind);
                rq.hour  = i_load_hour;
                rq.wday  = i_load_weekday;
                rq.mday  = i_load_monthday;
                rq.month = i_load_month;
                rq.year  = i_load_year;
                pending_readouts.push_back(advance_calendar(rq));
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_readouts.size() == 0) begin
                    $display("%0t ns: readout with no request pending, expected none, got hour %0d",
                             $time, o_hour_now);
                    mismatch_count++;
                end else begin
                    exp_r = pending_readouts.pop_front();
                    report_field("hour_now", exp_r.hour, o_hour_now);
                    report_field("weekday_now", exp_r.wday, o_weekday_now);
                    report_field("monthday_now", exp_r.mday, o_monthday_now);
                    report_field("month_now", exp_r.month, o_month_now);
                    report_field("year_now", exp_r.year, o_year_now);
                    report_field("phase", exp_r.phase, o_phase);
                    report_field("is_pm", exp_r.is_pm, o_is_pm);
                    report_field("clock12", exp_r.clock12, o_clock12);
                    report_field("phase_starts", exp_r.starts, o_phase_starts);
                end
            end
        end
    end

    // hold ready low for a requested stretch, otherwise stall at random
    always @(negedge i_clk) begin
        if (holdoff_left != 0) begin
            holdoff_left = holdoff_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(t_cal_request rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= rq.kind;
        i_load_hour     <= rq.hour;
        i_load_weekday  <= rq.wday;
        i_load_monthday <= rq.mday;
        i_load_month    <= rq.month;
        i_load_year     <= rq.year;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_load(int hour, int wday, int mday, int month, int year);
        t_cal_request rq;
        rq.kind  = KIND_LOAD;
        rq.hour  = HOUR_W'(hour);
        rq.wday  = WDAY_W'(wday);
        rq.mday  = MDAY_W'(mday);
        rq.month = MONTH_W'(month);
        rq.year  = YEAR_W'(year);
        send_request(rq);
    endtask

    task automatic send_ticks(int count);
        t_cal_request rq;
        for (int n = 0; n < count; n++) begin
            rq      = t_cal_request'({$urandom, $urandom});
            rq.kind = KIND_TICK;
            send_request(rq);
        end
    endtask

    task automatic wait_readouts_drained();
        i_in_valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_month_word(int idx, t_month_word word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= word;
        @(posedge i_clk);
        cal_words[idx] = word;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_month_word random_month_word();
        t_month_word w;
        w = t_month_word'($urandom);
        case ($urandom_range(3))
            0: w[MDAY_W-1:0] = MDAY_W'($urandom_range(1, 3));
            1: w[MDAY_W-1:0] = MDAY_W'(30);
            2: begin
                w[MDAY_W-1:0] = MDAY_W'($urandom_range(1, 6));
                for (int i = 0; i < NUM_PHASE; i++)
                    w[MDAY_W + START_W * i +: START_W] = START_W'(6 * i + $urandom_range(5));
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic t_cal_request random_request(int load_pct);
        t_cal_request rq;
        rq = t_cal_request'({$urandom, $urandom});
        rq.kind = ($urandom_range(99) < load_pct) ? KIND_LOAD : KIND_TICK;
        case ($urandom_range(3))
            0: ;
            1: begin
                rq.hour  = HOUR_W'(HOURS_IN_DAY - 1 - $urandom_range(2));
                rq.mday  = MDAY_W'($urandom_range(5));
                rq.month = MONTH_W'(MONTHS_IN_YEAR - 1);
                rq.year  = YEAR_MAX - YEAR_W'($urandom_range(2));
            end
            default: begin
                rq.hour  = HOUR_W'($urandom_range(HOURS_IN_DAY - 1));
                rq.wday  = WDAY_W'($urandom_range(DAYS_IN_WEEK - 1));
                rq.mday  = MDAY_W'($urandom_range(29));
                rq.month = MONTH_W'($urandom_range(MONTHS_IN_YEAR - 1));
            end
        endcase
        return rq;
    endfunction

    task automatic test_directed_loads();
        send_ticks(1);
        send_load(31, 3, 63, 3, 65535);
        send_ticks(1);
        send_load(0, 0, 0, 0, 0);
        send_ticks(1);
        send_load(23, 2, 29, 3, 65534);
        send_ticks(1);
        send_load(23, 2, 29, 3, 65535);
        send_ticks(1);
        send_load(11, 0, 0, 0, 0);
        send_ticks(1);
        send_load(5, 1, 10, 0, 100);
        send_ticks(3);
    endtask

    task automatic test_month_word_extremes();
        wait_readouts_drained();
        for (int m = 0; m < NUM_MONTH; m++)
            write_month_word(m, '0);
        send_load(3, 0, 5, 2, 65533);
        send_ticks(5);
        wait_readouts_drained();
        for (int m = 0; m < NUM_MONTH; m++)
            write_month_word(m, '1);
        send_load(30, 0, 62, 1, 7);
        send_ticks(2);
        wait_readouts_drained();
        for (int m = 0; m < NUM_MONTH; m++)
            write_month_word(m, WORD_RESET[m]);
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int chunk = 0; chunk < 4; chunk++) begin
            wait_readouts_drained();
            for (int m = 0; m < NUM_MONTH; m++)
                write_month_word(m, (chunk == 3) ? WORD_RESET[m] : random_month_word());
            for (int n = 0; n < count / 4; n++)
                send_request(random_request(15));
        end
    endtask

    task automatic test_input_backpressure();
        wait_readouts_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_left  = HOLDOFF_CYCLES;
        for (int n = 0; n < 40; n++)
            send_request(random_request(30));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_kind          = KIND_TICK;
        i_load_hour     = '0;
        i_load_weekday  = '0;
        i_load_monthday = '0;
        i_load_month    = '0;
        i_load_year     = '0;
        i_out_ready     = 1'b0;
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        holdoff_left    = 0;
        quiet_cycles    = 0;
        for (int m = 0; m < NUM_MONTH; m++)
            cal_words[m] = WORD_RESET[m];
        cal_hour  = '0;
        cal_wday  = '0;
        cal_mday  = '0;
        cal_month = '0;
        cal_year  = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_loads();
        test_month_word_extremes();
        test_random_traffic(7, 79, 560);
        test_random_traffic(79, 7, 560);
        test_random_traffic(0, 0, 560);
        test_input_backpressure();

        wait_readouts_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
